FILE: rtl/hee_pkg.sv
// Package for the even/odd Hamming encoder: field widths, register indexes
// and the constant position tables used by the encoder datapath.
// Depends on nothing.
package hee_pkg;

    // Field widths fixed by the interface.
    localparam int DATA_W = 26;
    localparam int CODE_W = 31;
    localparam int LEN_W  = 5;
    localparam int CHK_W  = 3;

    // Number of check positions (1, 2, 4, 8, 16) that fit in a codeword.
    localparam int CHK_POS = 5;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DATA_LENGTH = 1'b0,
        CFG_ODD_PARITY  = 1'b1
    } t_cfg_idx;

    // Scatter data bits into the non-power-of-two positions of a codeword.
    // Data bit j lands on the (j+1)-th such position counted from position 1,
    // so the map does not depend on the configured length.
    function automatic logic [CODE_W-1:0] scatter_data(input logic [DATA_W-1:0] word);
        logic [CODE_W-1:0] code;
        int k;
        code = '0;
        k = 0;
        for (int p = 1; p <= CODE_W; p++) begin
            if ((p & (p - 1)) != 0) begin
                code[p-1] = word[k];
                k++;
            end
        end
        return code;
    endfunction

    // Positions covered by check bit i: every position whose index has bit i set.
    function automatic logic [CODE_W-1:0] cover_mask(input int i);
        logic [CODE_W-1:0] m;
        for (int p = 1; p <= CODE_W; p++) begin
            m[p-1] = ((p >> i) & 1) != 0;
        end
        return m;
    endfunction

endpackage

FILE: rtl/hamming_encoder_even_odd_top.sv
// Top level of the even/odd Hamming encoder: configuration registers,
// input register stage and result register stage.
// Depends on hee_pkg.

// Encodes one data word per clock into a Hamming codeword with even or odd
// check bits. An accepted item is first held in the input register, where the
// length is clamped and the check-bit count chosen, and from there it passes
// through the scatter and parity XOR trees
// into the result register. Both stages advance together, so a new item is
// taken every cycle while the output side is not stalled. Configuration
// (data length, parity sense) must be written only while no item is in flight;
// the configuration port is always ready.
module hamming_encoder_even_odd_top #(
    parameter int MAX_CHECK_BITS = 5
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [hee_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [hee_pkg::LEN_W-1:0]          i_cfg_data,
    // Input item channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [hee_pkg::DATA_W-1:0]         i_data_word,
    // Result item channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [hee_pkg::CODE_W-1:0]         o_codeword,
    output logic [hee_pkg::LEN_W-1:0]          o_codeword_length,
    output logic                               o_leading_zero
);

    // Largest data length that fits the check-bit budget and the data field.
    localparam int FIT_LEN   = (2 ** MAX_CHECK_BITS) - MAX_CHECK_BITS - 1;
    localparam int LEN_LIMIT = (FIT_LEN < hee_pkg::DATA_W) ? FIT_LEN : hee_pkg::DATA_W;

    // Configuration registers
    logic [hee_pkg::LEN_W-1:0] r_data_length;
    logic                      r_odd_parity;

    // Input stage
    logic                      r_s1_valid;
    logic [hee_pkg::DATA_W-1:0] r_s1_word;
    logic [hee_pkg::LEN_W-1:0] r_s1_len;
    logic [hee_pkg::CHK_W-1:0] r_s1_nchk;
    logic                      r_s1_odd;
    logic                      r_s1_lead;

    // Result stage
    logic                      r_out_valid;
    logic [hee_pkg::CODE_W-1:0] r_out_code;
    logic [hee_pkg::LEN_W-1:0] r_out_len;
    logic                      r_out_lead;

    logic                      out_free;
    logic                      s1_free;
    logic                      in_take;

    logic [hee_pkg::LEN_W-1:0] n_len;
    logic [hee_pkg::CHK_W-1:0] n_nchk;
    logic [hee_pkg::DATA_W-1:0] n_word;
    logic                      n_lead;
    logic [hee_pkg::CODE_W-1:0] n_code;
    logic [hee_pkg::LEN_W-1:0] n_code_len;

    // Handshake: the result register frees when taken, the input stage when
    // it can move forward.
    assign out_free    = !r_out_valid || !i_out_stall;
    assign s1_free     = !r_s1_valid || out_free;
    assign in_take     = i_in_valid && s1_free;
    assign o_in_stall  = !s1_free;
    assign o_cfg_ready = 1'b1;

    // Configuration writes; an unknown index is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_length <= hee_pkg::LEN_W'(4);
            r_odd_parity  <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (hee_pkg::t_cfg_idx'(i_cfg_index))
                hee_pkg::CFG_DATA_LENGTH: r_data_length <= i_cfg_data;
                hee_pkg::CFG_ODD_PARITY:  r_odd_parity  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Clamp the length, mask spare input bits and pick the fewest check bits.
    always_comb begin
        priority if (r_data_length == '0) begin
            n_len = hee_pkg::LEN_W'(1);
        end else if (int'(r_data_length) > LEN_LIMIT) begin
            n_len = hee_pkg::LEN_W'(LEN_LIMIT);
        end else begin
            n_len = r_data_length;
        end
        n_word = i_data_word & ~({hee_pkg::DATA_W{1'b1}} << n_len);
        n_lead = !i_data_word[n_len - hee_pkg::LEN_W'(1)];
        n_nchk = hee_pkg::CHK_W'(MAX_CHECK_BITS);
        for (int rr = MAX_CHECK_BITS - 1; rr >= 1; rr--) begin
            if ((2 ** rr) >= int'(n_len) + rr + 1) begin
                n_nchk = hee_pkg::CHK_W'(rr);
            end
        end
    end

    // Input register stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_in_valid;
        end
        if (in_take) begin
            r_s1_word <= n_word;
            r_s1_len  <= n_len;
            r_s1_nchk <= n_nchk;
            r_s1_odd  <= r_odd_parity;
            r_s1_lead <= n_lead;
        end
    end

    // Scatter the data bits, then fill in the check bits from XOR trees.
    always_comb begin
        n_code = hee_pkg::scatter_data(r_s1_word);
        for (int i = 0; i < hee_pkg::CHK_POS; i++) begin
            if (i < int'(r_s1_nchk)) begin
                n_code[(2 ** i) - 1] = (^(n_code & hee_pkg::cover_mask(i))) ^ r_s1_odd;
            end
        end
        n_code_len = r_s1_len + hee_pkg::LEN_W'(r_s1_nchk);
    end

    // Result register stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
        if (out_free && r_s1_valid) begin
            r_out_code <= n_code;
            r_out_len  <= n_code_len;
            r_out_lead <= r_s1_lead;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_codeword        = r_out_code;
    assign o_codeword_length = r_out_len;
    assign o_leading_zero    = r_out_lead;

    // The input side only stalls when both stages hold items and output is stalled.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a full pipeline");

    // An accepted item always occupies the input stage on the next cycle.
    a_take_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_s1_valid)
        else $error("accepted item lost in input stage");

    // A codeword is at least three positions long.
    a_min_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_len >= hee_pkg::LEN_W'(3)))
        else $error("codeword length below three");

    // No bits are set above the codeword length.
    a_upper_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_code >> r_out_len) == '0))
        else $error("codeword bits set above its length");

    // The highest codeword position holds the top data bit, bit length-1.
    a_lead_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_lead == !r_out_code[r_out_len - hee_pkg::LEN_W'(1)]))
        else $error("leading zero flag disagrees with codeword");

endmodule
